// File: design/slbp_pkg.sv
package slbp_pkg;

    localparam int unsigned PAGE_BYTES_DEF = 2048;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_END_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_HIGH   = 2'd2;

    localparam logic [31:0] END_ADDRESS_RST = 32'h0000_0000;
    localparam logic [31:0] BANK_LOW_RST    = 32'h0800_8000;
    localparam logic [31:0] BANK_HIGH_RST   = 32'h0802_3FFF;

    localparam logic [7:0] CMD_ERASE     = 8'h31;
    localparam logic [7:0] CMD_ERASE_INV = 8'hCE;
    localparam logic [7:0] CMD_FINAL     = 8'h21;
    localparam logic [7:0] CMD_FINAL_INV = 8'hDE;
    localparam logic [7:0] CHAR_W        = 8'h57;
    localparam logic [7:0] CHAR_H        = 8'h68;
    localparam logic [7:0] CHAR_O        = 8'h6F;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_CR       = 8'h0D;

    localparam int unsigned OUT_DATA_W = 96;

    typedef enum logic [1:0] {
        REPLY_NONE   = 2'd0,
        REPLY_ACK    = 2'd1,
        REPLY_NAK    = 2'd2,
        REPLY_BANNER = 2'd3
    } reply_t;

    typedef struct packed {
        logic [31:0] end_address;
        logic [31:0] bank_low;
        logic [31:0] bank_high;
    } cfg_t;

    typedef struct packed {
        reply_t      reply;
        logic        erase_req;
        logic [31:0] erase_addr;
        logic        stage_valid;
        logic [7:0]  stage_offset;
        logic [7:0]  stage_byte;
        logic        commit_req;
        logic [31:0] commit_addr;
        logic [7:0]  commit_len;
        logic        busy_res;
        logic        finished;
    } result_t;

endpackage

// File: design/slbp_cfg.sv
module slbp_cfg
    import slbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_address <= END_ADDRESS_RST;
            cfg_reg.bank_low    <= BANK_LOW_RST;
            cfg_reg.bank_high   <= BANK_HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_END_ADDRESS: cfg_reg.end_address <= cfg_data;
                CFG_BANK_LOW:    cfg_reg.bank_low    <= cfg_data;
                CFG_BANK_HIGH:   cfg_reg.bank_high   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/slbp_engine.sv
module slbp_engine
    import slbp_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    localparam int unsigned PAGE_W = $clog2(PAGE_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARG   = 2'd1,
        PH_DATA  = 2'd2,
        PH_SPARE = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  command_code_reg, command_code_next;
    logic [2:0]  position_reg, position_next;
    logic [31:0] argument_bytes_reg, argument_bytes_next;
    logic [31:0] target_address_reg, target_address_next;
    logic [7:0]  block_length_reg, block_length_next;
    logic [8:0]  block_count_reg, block_count_next;
    logic [7:0]  block_check_reg, block_check_next;
    logic        busy_flag_reg, busy_flag_next;
    logic        finished_flag_reg, finished_flag_next;

    logic [7:0]  arg_xor;
    logic        arg_bad;

    assign arg_xor = argument_bytes_reg[31:24] ^ argument_bytes_reg[23:16]
                   ^ argument_bytes_reg[15:8] ^ argument_bytes_reg[7:0];
    assign arg_bad = (rx_byte != arg_xor) || (argument_bytes_reg < cfg.bank_low)
                   || (argument_bytes_reg > cfg.bank_high);

    always_comb
    begin
        phase_next          = phase_reg;
        command_code_next   = command_code_reg;
        position_next       = position_reg;
        argument_bytes_next = argument_bytes_reg;
        target_address_next = target_address_reg;
        block_length_next   = block_length_reg;
        block_count_next    = block_count_reg;
        block_check_next    = block_check_reg;
        busy_flag_next      = busy_flag_reg;
        finished_flag_next  = finished_flag_reg;
        res                 = '0;
        res.reply           = REPLY_NONE;

        unique case (phase_reg)
            PH_ARG:
            begin
                if (position_reg < 3'd4)
                begin
                    argument_bytes_next = {argument_bytes_reg[23:0], rx_byte};
                    position_next       = position_reg + 3'd1;
                end
                else
                begin
                    position_next = 3'd0;
                    if (arg_bad)
                    begin
                        res.reply = REPLY_NAK;
                    end
                    else if (command_code_reg == CMD_ERASE)
                    begin
                        res.reply           = REPLY_ACK;
                        target_address_next = argument_bytes_reg;
                        phase_next          = PH_DATA;
                        busy_flag_next      = 1'b1;
                        if (argument_bytes_reg[PAGE_W-1:0] == '0)
                        begin
                            res.erase_req  = 1'b1;
                            res.erase_addr = argument_bytes_reg;
                        end
                    end
                    else if (command_code_reg == CMD_FINAL)
                    begin
                        if (argument_bytes_reg == cfg.end_address)
                        begin
                            res.reply          = REPLY_ACK;
                            busy_flag_next     = 1'b0;
                            finished_flag_next = 1'b1;
                        end
                        else
                        begin
                            res.reply = REPLY_NAK;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                if (block_count_reg == 9'd0)
                begin
                    block_length_next = rx_byte;
                    block_check_next  = rx_byte + 8'd1;
                    block_count_next  = 9'd1;
                end
                else if (block_count_reg < ({1'b0, block_length_reg} + 9'd1))
                begin
                    res.stage_valid  = 1'b1;
                    res.stage_offset = 8'(block_count_reg - 9'd1);
                    res.stage_byte   = rx_byte;
                    block_check_next = block_check_reg ^ rx_byte;
                    block_count_next = block_count_reg + 9'd1;
                end
                else if (rx_byte != block_check_reg)
                begin
                    res.reply = REPLY_NAK;
                end
                else
                begin
                    res.reply       = REPLY_ACK;
                    res.commit_req  = 1'b1;
                    res.commit_addr = {target_address_reg[31:8], 8'h00};
                    res.commit_len  = block_length_reg;
                end
            end
            PH_IDLE, PH_SPARE:
            begin
                unique case (position_reg)
                    3'd0:
                    begin
                        if (rx_byte == CHAR_W)
                        begin
                            position_next = 3'd1;
                        end
                        else if (rx_byte == CMD_FINAL || rx_byte == CMD_ERASE)
                        begin
                            command_code_next = rx_byte;
                            position_next     = 3'd1;
                        end
                        else
                        begin
                            command_code_next = 8'h00;
                            position_next     = 3'd0;
                        end
                    end
                    3'd1:
                    begin
                        if (rx_byte == CHAR_H)
                        begin
                            position_next = 3'd2;
                        end
                        else if ((rx_byte == CMD_FINAL_INV && command_code_reg == CMD_FINAL)
                              || (rx_byte == CMD_ERASE_INV && command_code_reg == CMD_ERASE))
                        begin
                            res.reply         = REPLY_ACK;
                            command_code_next = ~rx_byte;
                            phase_next        = PH_ARG;
                        end
                        else
                        begin
                            res.reply = REPLY_NAK;
                        end
                    end
                    3'd2:    position_next = (rx_byte == CHAR_O) ? 3'd3 : 3'd0;
                    3'd3:    position_next = (rx_byte == CHAR_QUESTION) ? 3'd4 : 3'd0;
                    3'd4:
                    begin
                        if (rx_byte == CHAR_CR)
                        begin
                            res.reply = REPLY_BANNER;
                        end
                        position_next = 3'd0;
                    end
                    default: position_next = 3'd0;
                endcase
            end
            default: ;
        endcase

        // Any reply ends the current frame.
        if (res.reply != REPLY_NONE)
        begin
            position_next     = 3'd0;
            block_count_next  = 9'd0;
            block_length_next = 8'd0;
            block_check_next  = 8'd0;
        end

        res.busy_res = busy_flag_next;
        res.finished = finished_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            command_code_reg   <= 8'h00;
            position_reg       <= 3'd0;
            argument_bytes_reg <= 32'h0;
            target_address_reg <= 32'h0;
            block_length_reg   <= 8'h00;
            block_count_reg    <= 9'd0;
            block_check_reg    <= 8'h00;
            busy_flag_reg      <= 1'b0;
            finished_flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            command_code_reg   <= command_code_next;
            position_reg       <= position_next;
            argument_bytes_reg <= argument_bytes_next;
            target_address_reg <= target_address_next;
            block_length_reg   <= block_length_next;
            block_count_reg    <= block_count_next;
            block_check_reg    <= block_check_next;
            busy_flag_reg      <= busy_flag_next;
            finished_flag_reg  <= finished_flag_next;
        end
    end

endmodule

// File: design/serial_loader_byte_protocol.sv
// Byte-level loader protocol engine: each received byte is one input item and
// yields exactly one result item carrying the reply code (none, ACK, NAK or
// banner), erase and commit requests, the payload byte to stage and the busy
// and finished flags. An item passes through an input register and a result
// register with the protocol logic between them, so a byte can be taken every
// clock cycle unless the result side stalls; a result that is not taken holds
// the next byte in the input register. The user must write the configuration
// registers only while no item is in flight; the block does not enforce this.
module serial_loader_byte_protocol
    import slbp_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // rx_byte[7:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // reply[1:0], erase_req[2], erase_addr[34:3], stage_valid[35],
    // stage_offset[43:36], stage_byte[51:44], commit_req[52],
    // commit_addr[84:53], commit_len[92:85], busy_res[93], finished[94], zero[95]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    result_t    res;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    slbp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slbp_engine #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.finished,
                            out_res_reg.busy_res,
                            out_res_reg.commit_len,
                            out_res_reg.commit_addr,
                            out_res_reg.commit_req,
                            out_res_reg.stage_byte,
                            out_res_reg.stage_offset,
                            out_res_reg.stage_valid,
                            out_res_reg.erase_addr,
                            out_res_reg.erase_req,
                            out_res_reg.reply};

endmodule

// File: tb/serial_loader_byte_protocol_test.sv
`timescale 1ns / 100ps

module serial_loader_byte_protocol_test
    import slbp_pkg::*;
();

    localparam logic [31:0] PAGE_MASK   = PAGE_BYTES_DEF - 1;
    localparam logic [31:0] COMMIT_MASK = 32'hFFFF_FF00;
    localparam int TOTAL_BYTES  = 1550;
    localparam int HOLD_AFTER   = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;

    typedef enum logic [1:0] {
        LDR_IDLE = 2'd0,
        LDR_ARG  = 2'd1,
        LDR_DATA = 2'd2
    } loader_phase_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       pinned;
        reply_t     reply;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Protocol state as the block should hold it.
    loader_phase_t ldr_phase;
    logic [7:0]    ldr_cmd;
    logic [2:0]    ldr_pos;
    logic [31:0]   ldr_arg;
    logic [31:0]   ldr_target;
    logic [7:0]    ldr_len;
    logic [8:0]    ldr_count;
    logic [7:0]    ldr_xor;
    logic          ldr_busy;
    logic          ldr_done;
    logic [31:0]   cfg_end;
    logic [31:0]   cfg_low;
    logic [31:0]   cfg_high;

    result_t expected_results [$];
    int      errors = 0;
    int      results_seen = 0;
    int      bytes_sent = 0;
    bit      tx_burst = 1'b0;

    serial_loader_byte_protocol i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] arg_check(input logic [31:0] v);
        return v[31:24] ^ v[23:16] ^ v[15:8] ^ v[7:0];
    endfunction

    function automatic int idle_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(0, 2);
    endfunction

    function automatic result_t advance_protocol(input logic [7:0] b);
        result_t    r;
        logic [8:0] offset;
        r = '0;
        r.reply = REPLY_NONE;
        case (ldr_phase)
            LDR_ARG:
            begin
                if (ldr_pos < 3'd4)
                begin
                    ldr_arg = {ldr_arg[23:0], b};
                    ldr_pos = ldr_pos + 3'd1;
                end
                else
                begin
                    ldr_pos = 3'd0;
                    if (b != arg_check(ldr_arg) || ldr_arg < cfg_low || ldr_arg > cfg_high)
                    begin
                        r.reply = REPLY_NAK;
                    end
                    else if (ldr_cmd == CMD_ERASE)
                    begin
                        r.reply = REPLY_ACK;
                        ldr_target = ldr_arg;
                        ldr_phase = LDR_DATA;
                        ldr_busy = 1'b1;
                        if ((ldr_arg & PAGE_MASK) == 32'd0)
                        begin
                            r.erase_req = 1'b1;
                            r.erase_addr = ldr_arg;
                        end
                    end
                    else if (ldr_cmd == CMD_FINAL)
                    begin
                        if (ldr_arg == cfg_end)
                        begin
                            r.reply = REPLY_ACK;
                            ldr_busy = 1'b0;
                            ldr_done = 1'b1;
                        end
                        else
                        begin
                            r.reply = REPLY_NAK;
                        end
                    end
                end
            end
            LDR_DATA:
            begin
                if (ldr_count == 9'd0)
                begin
                    ldr_len = b;
                    ldr_xor = b + 8'd1;
                    ldr_count = 9'd1;
                end
                else if (ldr_count < {1'b0, ldr_len} + 9'd1)
                begin
                    offset = ldr_count - 9'd1;
                    r.stage_valid = 1'b1;
                    r.stage_offset = offset[7:0];
                    r.stage_byte = b;
                    ldr_xor = ldr_xor ^ b;
                    ldr_count = ldr_count + 9'd1;
                end
                else if (b != ldr_xor)
                begin
                    r.reply = REPLY_NAK;
                end
                else
                begin
                    r.reply = REPLY_ACK;
                    r.commit_req = 1'b1;
                    r.commit_addr = ldr_target & COMMIT_MASK;
                    r.commit_len = ldr_len;
                end
            end
            default:
            begin
                case (ldr_pos)
                    3'd0:
                    begin
                        if (b == CHAR_W)
                        begin
                            ldr_pos = 3'd1;
                        end
                        else if (b == CMD_FINAL || b == CMD_ERASE)
                        begin
                            ldr_cmd = b;
                            ldr_pos = 3'd1;
                        end
                        else
                        begin
                            ldr_cmd = 8'd0;
                        end
                    end
                    3'd1:
                    begin
                        if (b == CHAR_H)
                        begin
                            ldr_pos = 3'd2;
                        end
                        else if ((b == CMD_FINAL_INV && ldr_cmd == CMD_FINAL) ||
                                 (b == CMD_ERASE_INV && ldr_cmd == CMD_ERASE))
                        begin
                            r.reply = REPLY_ACK;
                            ldr_cmd = ~b;
                            ldr_phase = LDR_ARG;
                        end
                        else
                        begin
                            r.reply = REPLY_NAK;
                        end
                    end
                    3'd2:
                    begin
                        ldr_pos = (b == CHAR_O) ? 3'd3 : 3'd0;
                    end
                    3'd3:
                    begin
                        ldr_pos = (b == CHAR_QUESTION) ? 3'd4 : 3'd0;
                    end
                    3'd4:
                    begin
                        if (b == CHAR_CR)
                        begin
                            r.reply = REPLY_BANNER;
                        end
                        ldr_pos = 3'd0;
                    end
                    default:
                    begin
                        ldr_pos = 3'd0;
                    end
                endcase
            end
        endcase
        if (r.reply != REPLY_NONE)
        begin
            ldr_pos = 3'd0;
            ldr_count = 9'd0;
            ldr_len = 8'd0;
            ldr_xor = 8'd0;
        end
        r.busy_res = ldr_busy;
        r.finished = ldr_done;
        return r;
    endfunction

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_END_ADDRESS: cfg_end = value;
            CFG_BANK_LOW:    cfg_low = value;
            default:         cfg_high = value;
        endcase
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_rx(input logic [7:0] b, input logic pinned, input reply_t pinned_reply);
        int      gap;
        result_t outcome;
        if ($urandom_range(0, 99) < 3)
        begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : idle_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(negedge clk);
        while (!s_axis_tready) @(negedge clk);
        @(posedge clk);
        outcome = advance_protocol(b);
        if (pinned)
        begin
            outcome = '0;
            outcome.reply = pinned_reply;
        end
        expected_results.push_back(outcome);
        bytes_sent++;
    endtask

    task automatic send_arg_frame(input logic [31:0] v, input logic [7:0] check);
        for (int k = 3; k >= 0; k--)
        begin
            send_rx(v[k*8 +: 8], 1'b0, REPLY_NONE);
        end
        send_rx(check, 1'b0, REPLY_NONE);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.reply = reply_t'(m_axis_tdata[1:0]);
            got.erase_req = m_axis_tdata[2];
            got.erase_addr = m_axis_tdata[34:3];
            got.stage_valid = m_axis_tdata[35];
            got.stage_offset = m_axis_tdata[43:36];
            got.stage_byte = m_axis_tdata[51:44];
            got.commit_req = m_axis_tdata[52];
            got.commit_addr = m_axis_tdata[84:53];
            got.commit_len = m_axis_tdata[92:85];
            got.busy_res = m_axis_tdata[93];
            got.finished = m_axis_tdata[94];
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("reply", 32'(want.reply), 32'(got.reply));
                compare_field("erase_req", 32'(want.erase_req), 32'(got.erase_req));
                compare_field("erase_addr", want.erase_addr, got.erase_addr);
                compare_field("stage_valid", 32'(want.stage_valid), 32'(got.stage_valid));
                compare_field("stage_offset", 32'(want.stage_offset),
                              32'(got.stage_offset));
                compare_field("stage_byte", 32'(want.stage_byte), 32'(got.stage_byte));
                compare_field("commit_req", 32'(want.commit_req), 32'(got.commit_req));
                compare_field("commit_addr", want.commit_addr, got.commit_addr);
                compare_field("commit_len", 32'(want.commit_len), 32'(got.commit_len));
                compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                compare_field("finished", 32'(want.finished), 32'(got.finished));
                compare_field("padding", 32'd0, 32'(m_axis_tdata[95]));
            end
            results_seen++;
        end
    end

    // The result side stalls at random and, once, holds off long enough for the
    // block to fill up and push back on the byte stream.
    initial
    begin : result_sink
        int stall;
        bit rx_burst;
        bit held;
        rx_burst = 1'b0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    rx_burst = !rx_burst;
                end
                stall = rx_burst ? 0 : idle_gap();
                if (stall != 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : byte_source
        logic [7:0]    seq [$];
        logic [7:0]    rx;
        logic [7:0]    x;
        logic [7:0]    flip;
        logic [31:0]   v;
        logic [31:0]   lo;
        logic [31:0]   hi;
        int            len;
        int            long_blocks;
        directed_row_t directed_rows [22];

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_END_ADDRESS;
        cfg_data = '0;
        long_blocks = 0;

        ldr_phase = LDR_IDLE;
        ldr_cmd = 8'd0;
        ldr_pos = 3'd0;
        ldr_arg = 32'd0;
        ldr_target = 32'd0;
        ldr_len = 8'd0;
        ldr_count = 9'd0;
        ldr_xor = 8'd0;
        ldr_busy = 1'b0;
        ldr_done = 1'b0;
        cfg_end = END_ADDRESS_RST;
        cfg_low = BANK_LOW_RST;
        cfg_high = BANK_HIGH_RST;

        // Keepalive, broken keepalives, and command bytes that do not pair up.
        directed_rows = '{
            '{CHAR_W,        1'b1, REPLY_NONE},
            '{CHAR_H,        1'b1, REPLY_NONE},
            '{CHAR_O,        1'b1, REPLY_NONE},
            '{CHAR_QUESTION, 1'b1, REPLY_NONE},
            '{CHAR_CR,       1'b1, REPLY_BANNER},
            '{CHAR_W,        1'b0, REPLY_NONE},
            '{CHAR_H,        1'b0, REPLY_NONE},
            '{8'h78,         1'b0, REPLY_NONE},
            '{CHAR_W,        1'b0, REPLY_NONE},
            '{8'h00,         1'b1, REPLY_NAK},
            '{CHAR_W,        1'b0, REPLY_NONE},
            '{CHAR_H,        1'b0, REPLY_NONE},
            '{CHAR_O,        1'b0, REPLY_NONE},
            '{CHAR_QUESTION, 1'b0, REPLY_NONE},
            '{8'h0A,         1'b0, REPLY_NONE},
            '{CMD_FINAL,     1'b0, REPLY_NONE},
            '{8'hFF,         1'b1, REPLY_NAK},
            '{CHAR_W,        1'b0, REPLY_NONE},
            '{CMD_ERASE_INV, 1'b1, REPLY_NAK},
            '{CMD_ERASE,     1'b0, REPLY_NONE},
            '{CMD_FINAL_INV, 1'b1, REPLY_NAK},
            '{8'h00,         1'b0, REPLY_NONE}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_cfg(CFG_END_ADDRESS, $urandom);

        foreach (directed_rows[k])
        begin
            send_rx(directed_rows[k].rx, directed_rows[k].pinned, directed_rows[k].reply);
        end

        // Idle traffic. A command complement that would leave idle is swapped for
        // a carriage return, since the protocol never returns to idle.
        repeat (60)
        begin
            seq.delete();
            rx = 8'($urandom);
            case ($urandom_range(0, 3))
                0:
                begin
                    seq = '{CHAR_W, CHAR_H, CHAR_O, CHAR_QUESTION, CHAR_CR};
                end
                1:
                begin
                    seq = '{CHAR_W, CHAR_H, CHAR_O, CHAR_QUESTION, CHAR_CR};
                    seq[$urandom_range(0, 4)] = rx;
                    repeat ($urandom_range(0, 2)) void'(seq.pop_back());
                end
                2:
                begin
                    seq = '{($urandom_range(0, 1) != 0) ? CMD_ERASE : CMD_FINAL, rx};
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        rx = 8'($urandom);
                        seq.push_back(rx);
                    end
                end
            endcase
            foreach (seq[k])
            begin
                rx = seq[k];
                if (ldr_pos == 3'd1 &&
                    ((rx == CMD_ERASE_INV && ldr_cmd == CMD_ERASE) ||
                     (rx == CMD_FINAL_INV && ldr_cmd == CMD_FINAL)))
                begin
                    rx = CHAR_CR;
                end
                send_rx(rx, 1'b0, REPLY_NONE);
            end
        end

        while (ldr_pos != 3'd0)
        begin
            send_rx(8'h00, 1'b0, REPLY_NONE);
        end
        send_rx(CMD_ERASE, 1'b0, REPLY_NONE);
        send_rx(CMD_ERASE_INV, 1'b1, REPLY_ACK);

        // Argument frames that must all be refused, under several bank settings.
        for (int n = 0; n < 4; n++)
        begin
            drain_results();
            case (n)
                1:
                begin
                    write_cfg(CFG_END_ADDRESS, $urandom);
                    write_cfg(CFG_BANK_LOW, 32'hFFFF_FFFF);
                    write_cfg(CFG_BANK_HIGH, 32'h0000_0000);
                end
                2:
                begin
                    write_cfg(CFG_BANK_LOW, 32'h0000_0000);
                    write_cfg(CFG_BANK_HIGH, 32'hFFFF_FFFF);
                end
                3:
                begin
                    lo = $urandom;
                    hi = $urandom;
                    if (lo > hi)
                    begin
                        v = lo;
                        lo = hi;
                        hi = v;
                    end
                    write_cfg(CFG_BANK_LOW, lo);
                    write_cfg(CFG_BANK_HIGH, hi);
                end
                default:
                begin
                end
            endcase
            repeat (15)
            begin
                case ($urandom_range(0, 4))
                    0:       v = cfg_low - 32'd1;
                    1:       v = cfg_high + 32'd1;
                    2:       v = cfg_low;
                    3:       v = cfg_high;
                    default: v = $urandom;
                endcase
                x = arg_check(v);
                flip = 8'($urandom_range(1, 255));
                if ((v >= cfg_low && v <= cfg_high) || $urandom_range(0, 2) == 0)
                begin
                    x = x ^ flip;
                end
                send_arg_frame(v, x);
            end
        end

        drain_results();
        write_cfg(CFG_BANK_LOW, BANK_LOW_RST);
        hi = ($urandom_range(0, 1) != 0) ? BANK_HIGH_RST : 32'hFFFF_FFFF;
        write_cfg(CFG_BANK_HIGH, hi);
        if ($urandom_range(0, 1) != 0)
        begin
            v = $urandom_range(BANK_LOW_RST >> 11, hi >> 11);
            v = v << 11;
        end
        else
        begin
            v = $urandom_range(BANK_LOW_RST, hi);
        end
        send_arg_frame(v, arg_check(v));

        // Payload blocks: mostly short, a few long, some with a bad check byte.
        while (bytes_sent < TOTAL_BYTES)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    len = (long_blocks < 2) ? 255 : 0;
                    long_blocks++;
                end
                1:          len = 0;
                2, 3, 4, 5: len = $urandom_range(9, 48);
                default:    len = $urandom_range(1, 8);
            endcase
            rx = 8'(len);
            send_rx(rx, 1'b0, REPLY_NONE);
            x = rx + 8'd1;
            repeat (len)
            begin
                rx = 8'($urandom);
                x = x ^ rx;
                send_rx(rx, 1'b0, REPLY_NONE);
            end
            flip = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 6) == 0)
            begin
                x = x ^ flip;
            end
            send_rx(x, 1'b0, REPLY_NONE);
        end

        drain_results();
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
